FILE: design/assert_macros.svh
// Assertion macros shared by the timer slot design.
// Clock clk and reset arst_n must be in scope where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: design/otps_pkg.sv
// Shared types and codes for the timer slot block.
// No dependencies.
package otps_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam logic [1:0] KIND_FIRE   = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BAD    = 2'd1;
	localparam logic [1:0] ST_ACTIVE = 2'd2;

	typedef enum logic [2:0] {
		CLS_TICK,
		CLS_TICK_OFF,
		CLS_START,
		CLS_STOP,
		CLS_REJECT
	} cls_t;

	typedef struct packed {
		cls_t        cls;
		logic [3:0]  slot;
		logic [31:0] interval;
		logic        periodic;
	} item_t;

endpackage

FILE: design/otps_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
// Depends on otps_pkg.
module otps_front #(
	parameter int NUM_SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              enable,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  logic [3:0]        slot,
	input  logic [31:0]       interval,
	input  logic              periodic,
	output logic              busy,
	input  logic              pop,
	output logic              q_valid,
	output otps_pkg::item_t   q_item
);

	otps_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            do_pop;
	otps_pkg::item_t cls_item;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign do_pop  = pop && q_valid;
	assign q_item  = fifo_q[rd_ptr_q];

	always_comb begin
		cls_item.slot     = slot;
		cls_item.interval = interval;
		cls_item.periodic = periodic;
		if (opcode == otps_pkg::OP_TICK) begin
			cls_item.cls = enable ? otps_pkg::CLS_TICK : otps_pkg::CLS_TICK_OFF;
		end else if (!enable || (32'(slot) >= NUM_SLOTS)) begin
			cls_item.cls = otps_pkg::CLS_REJECT;
		end else if (opcode == otps_pkg::OP_START) begin
			cls_item.cls = otps_pkg::CLS_START;
		end else if (opcode == otps_pkg::OP_STOP) begin
			cls_item.cls = otps_pkg::CLS_STOP;
		end else begin
			cls_item.cls = otps_pkg::CLS_REJECT;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

FILE: design/otps_back.sv
// Back end: executes queued commands and scans the slots on each enabled tick.
// Depends on otps_pkg; holds the interval and deadline memories.
module otps_back #(
	parameter int NUM_SLOTS     = 16,
	parameter int INTERVAL_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  otps_pkg::item_t q_item,
	output logic            pop,
	output logic            done,
	output logic [1:0]      kind,
	output logic [3:0]      fired_slot,
	output logic [1:0]      status,
	output logic            rescheduled,
	output logic [63:0]     now,
	output logic [4:0]      active_count,
	output logic            last
);

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW = $clog2(NUM_SLOTS + 1);
	localparam int IW = INTERVAL_BITS;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

	state_t               state_q;
	logic [63:0]          tick_q;
	logic [CW-1:0]        live_q;
	logic [NUM_SLOTS-1:0] act_q;
	logic [NUM_SLOTS-1:0] per_q;
	logic [NUM_SLOTS-1:0] fire_q;
	logic [SW:0]          scan_q;
	logic [SW:0]          emit_q;
	logic                 rd_vld_s1;
	logic [SW-1:0]        rd_idx_s1;
	logic [63:0]          dl_s1;
	logic [IW-1:0]        iv_s1;

	logic [IW-1:0]        iv_mem [NUM_SLOTS];
	logic [63:0]          dl_mem [NUM_SLOTS];

	logic [IW-1:0]        ival;
	logic [SW-1:0]        cmd_idx;
	logic [SW-1:0]        scan_idx;
	logic [SW-1:0]        emit_idx;
	logic                 hit;
	logic                 dl_we;
	logic [SW-1:0]        dl_wa;
	logic [63:0]          dl_wd;
	logic                 iv_we;

	assign ival     = IW'(q_item.interval);
	assign cmd_idx  = SW'(q_item.slot);
	assign scan_idx = scan_q[SW-1:0];
	assign emit_idx = emit_q[SW-1:0];
	assign pop      = (state_q == S_IDLE) && q_valid;
	assign hit      = rd_vld_s1 && act_q[rd_idx_s1] && (tick_q >= dl_s1);

	// Memory write port: a start in idle, or a periodic reload during the scan.
	always_comb begin
		iv_we = pop && (q_item.cls == otps_pkg::CLS_START) && (ival != '0)
			&& !act_q[cmd_idx];
		dl_we = iv_we;
		dl_wa = cmd_idx;
		dl_wd = tick_q + 64'(ival);
		if (state_q == S_SCAN && hit && per_q[rd_idx_s1]) begin
			dl_we = 1'b1;
			dl_wa = rd_idx_s1;
			dl_wd = tick_q + 64'(iv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (iv_we) begin
			iv_mem[cmd_idx] <= ival;
		end
		if (dl_we) begin
			dl_mem[dl_wa] <= dl_wd;
		end
		dl_s1     <= dl_mem[scan_idx];
		iv_s1     <= iv_mem[scan_idx];
		rd_idx_s1 <= scan_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tick_q    <= '0;
			live_q    <= '0;
			act_q     <= '0;
			per_q     <= '0;
			fire_q    <= '0;
			scan_q    <= '0;
			emit_q    <= '0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
			kind         <= '0;
			fired_slot   <= '0;
			status       <= '0;
			rescheduled  <= 1'b0;
			now          <= '0;
			active_count <= '0;
			last         <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (q_valid) begin
						fired_slot   <= q_item.slot;
						rescheduled  <= 1'b0;
						now          <= tick_q;
						active_count <= 5'(live_q);
						last         <= 1'b1;
						kind         <= otps_pkg::KIND_STATUS;
						status       <= otps_pkg::ST_BAD;
						unique case (q_item.cls)
							otps_pkg::CLS_TICK: begin
								tick_q  <= tick_q + 64'd1;
								fire_q  <= '0;
								scan_q  <= '0;
								state_q <= S_SCAN;
							end
							otps_pkg::CLS_TICK_OFF: begin
								done       <= 1'b1;
								kind       <= otps_pkg::KIND_TICK;
								fired_slot <= '0;
							end
							otps_pkg::CLS_START: begin
								done <= 1'b1;
								if (ival == '0) begin
									status <= otps_pkg::ST_BAD;
								end else if (act_q[cmd_idx]) begin
									status <= otps_pkg::ST_ACTIVE;
								end else begin
									status          <= otps_pkg::ST_OK;
									act_q[cmd_idx]  <= 1'b1;
									per_q[cmd_idx]  <= q_item.periodic;
									live_q          <= live_q + CW'(1);
									active_count    <= 5'(live_q + CW'(1));
								end
							end
							otps_pkg::CLS_STOP: begin
								done <= 1'b1;
								if (act_q[cmd_idx]) begin
									status         <= otps_pkg::ST_OK;
									act_q[cmd_idx] <= 1'b0;
									live_q         <= live_q - CW'(1);
									active_count   <= 5'(live_q - CW'(1));
								end
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					// Read one slot a cycle; judge it the cycle after.
					if (32'(scan_q) < NUM_SLOTS) begin
						rd_vld_s1 <= 1'b1;
						scan_q    <= scan_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (hit) begin
						fire_q[rd_idx_s1] <= 1'b1;
						if (!per_q[rd_idx_s1]) begin
							act_q[rd_idx_s1] <= 1'b0;
							live_q           <= live_q - CW'(1);
						end
					end
					if (!rd_vld_s1 && (32'(scan_q) >= NUM_SLOTS)) begin
						emit_q  <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					rd_vld_s1    <= 1'b0;
					now          <= tick_q;
					active_count <= 5'(live_q);
					status       <= otps_pkg::ST_OK;
					if (32'(emit_q) < NUM_SLOTS) begin
						emit_q      <= emit_q + 1'b1;
						done        <= fire_q[emit_idx];
						kind        <= otps_pkg::KIND_FIRE;
						fired_slot  <= 4'(emit_idx);
						rescheduled <= per_q[emit_idx];
						last        <= 1'b0;
					end else begin
						done        <= 1'b1;
						kind        <= otps_pkg::KIND_TICK;
						fired_slot  <= '0;
						rescheduled <= 1'b0;
						last        <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/oneshot_periodic_timer_slots_top.sv
// Top level of the multi-slot one-shot / periodic timer.
// Depends on otps_pkg, otps_front, otps_back and assert_macros.svh.
//
// Usage:
//  - Command channel: drive opcode, slot, interval and periodic with start high;
//    the beat is taken at a clock edge where busy is low. Opcode 0 is a tick,
//    1 arms a slot, 2 disarms it.
//  - Result channel: done marks each result beat for one cycle; the receiver
//    cannot stall it, so every beat must be taken as it comes.
//  - A command other than a tick gives one status beat, registered when the
//    back end takes it from the queue while idle.
//  - An enabled tick walks every slot twice, one slot a cycle: a first pass
//    judges deadlines and reloads or disarms, a second pass sends one fire
//    beat per due slot, then a tick-done beat with last high. The deadline
//    memory has a single read port.
//  - A two-beat queue sits between front and back, so busy rises only while
//    two beats wait behind a running tick.
//  - The enable register answers at every APB address; writes land in any
//    state but are only meaningful while idle.
//  - Reset clears time, all slot marks and the queue; no clearing pass runs.
module oneshot_periodic_timer_slots_top #(
	parameter int NUM_SLOTS     = 16,
	parameter int INTERVAL_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [3:0]  slot,
	input  logic [31:0] interval,
	input  logic        periodic,
	output logic        done,
	output logic [1:0]  kind,
	output logic [3:0]  fired_slot,
	output logic [1:0]  status,
	output logic        rescheduled,
	output logic [63:0] now,
	output logic [4:0]  active_count,
	output logic        last
);

	`include "assert_macros.svh"

	logic            enable_q;
	logic            pop;
	logic            q_valid;
	otps_pkg::item_t q_item;

	// Single register; every address in the window maps onto it.
	assign pready = 1'b1;
	assign prdata = {31'd0, enable_q} | {30'd0, paddr & 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			enable_q <= pwdata[0];
		end
	end

	otps_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (enable_q),
		.start    (start),
		.opcode   (opcode),
		.slot     (slot),
		.interval (interval),
		.periodic (periodic),
		.busy     (busy),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	otps_back #(
		.NUM_SLOTS     (NUM_SLOTS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.done         (done),
		.kind         (kind),
		.fired_slot   (fired_slot),
		.status       (status),
		.rescheduled  (rescheduled),
		.now          (now),
		.active_count (active_count),
		.last         (last)
	);

	// A fire beat is never the closing beat of its tick and always reports ok.
	`ASSERT_NOW(a_fire_shape, done && kind == otps_pkg::KIND_FIRE, !last && status == otps_pkg::ST_OK, "fire beat malformed")
	// Tick-done and status beats always close their input.
	`ASSERT_NOW(a_close, done && kind != otps_pkg::KIND_FIRE, last, "closing beat without last")
	// Only the back end's idle state drains the queue, and only when it holds a beat.
	`ASSERT_NOW(a_pop, pop, q_valid, "pop from empty queue")
	// An accepted beat always leaves the queue non-empty next cycle.
	`ASSERT_NEXT(a_push, start && !busy, q_valid, "accepted beat lost")

endmodule
